>>> rtl/cwm_pkg.sv
// shared constants, codes and control types of the climate window monitor
`default_nettype none

package cwm_pkg;

  // field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ScaledW = 19;  // magnitude of a scaling numerator
  localparam int unsigned QuotW   = 7;   // scaled humidity or temperature magnitude
  localparam int unsigned LevelW  = 12;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  // converter scaling
  localparam logic [SampleW-1:0] AdcOffset = 12'd16;
  localparam logic [LevelW-1:0]  FullScale = 12'd4065;
  localparam logic [6:0]         HumidGain = 7'd100;
  localparam logic [6:0]         TempGain  = 7'd95;
  localparam logic [ScaledW-1:0] TempBias  = 19'd42170;  // 16*95 + 10*4065

  // floor(2^31 / 4065), quotient estimate is low by at most one
  localparam logic [19:0] RecipMul = 20'd528286;

  // green level divider
  localparam int unsigned DivSteps = 12;
  localparam int unsigned DivCntW  = 4;

  // reset values of the registers
  localparam logic [LimitW-1:0] TempLowReset   = 8'd20;
  localparam logic [LimitW-1:0] TempHighReset  = 8'd37;
  localparam logic [LimitW-1:0] HumidLowReset  = 8'd30;
  localparam logic [LimitW-1:0] HumidHighReset = 8'd70;
  localparam logic [DelayW-1:0] DelayReset     = 16'd10000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegTempLow   = 3'd0,
    RegTempHigh  = 3'd1,
    RegHumidLow  = 3'd2,
    RegHumidHigh = 3'd3,
    RegDelay     = 3'd4
  } cfg_reg_e;

  // window classes
  typedef enum logic [1:0] {
    ClassNormal = 2'd0,
    ClassLow    = 2'd1,
    ClassHigh   = 2'd2
  } class_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic scale_mul;
    logic scale_fix;
    logic classify;
    logic div_step;
    logic load_out;
  } cwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } cwm_status_t;

endpackage

`default_nettype wire

>>> rtl/climate_window_monitor.sv
// top level of the climate window monitor: controller and datapath
//
// Usage: each input item carries a humidity and a temperature converter
// sample and a millisecond timestamp. The block scales both samples to
// percent and degrees Celsius, classes them against the window registers,
// drives red and green indicator levels and raises the alarm when a value
// has been out of its window longer than the delay register allows.
// An accepted item passes capture, reciprocal multiply, correction,
// classing, then the steps of the one-bit-a-cycle divider for the green
// level, then load into the output register once that register is free.
// One item is in flight at a time; a new one is taken only after load.
// The result sits in an output register, so a new item is taken while a
// finished result waits; a stalled receiver holds the block in its last
// step until the output register frees up.
// Reset: registers return to their default windows and delay, both
// normal-time stamps clear to zero and no result is pending.
// Write registers only while no item is in flight; the block does not check.
`default_nettype none

module climate_window_monitor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [cwm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [cwm_pkg::DelayW-1:0]  cfg_data_i,
  // input items
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // humid_sample[11:0], temp_sample[23:12], now_ms[55:24]
  input  wire logic [cwm_pkg::InDataW-1:0] s_axis_tdata,
  // result items
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // temp_value[7:0], humid_value[14:8], temp_class[16:15], humid_class[18:17],
  // red_level[30:19], green_level[42:31], alarm_on[43], zero[47:44]
  output logic [cwm_pkg::OutDataW-1:0]     m_axis_tdata
);

  cwm_pkg::cwm_cmd_t    cmd;
  cwm_pkg::cwm_status_t status;

  // item sequencer
  cwm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // arithmetic and state
  cwm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/cwm_ctrl.sv
// sequencer for one item: capture, scaling, classing, green divide, output
`default_nettype none

module cwm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire cwm_pkg::cwm_status_t status_i,
  output cwm_pkg::cwm_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_CLASS,
    S_DIV,
    S_OUT
  } state_e;

  state_e                       state_q, state_d;
  logic [cwm_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic                         accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = accept;
        if (accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.scale_mul = 1'b1;
        state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.scale_fix = 1'b1;
        state_d = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cwm_pkg::DivCntW'(cwm_pkg::DivSteps - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cwm_dp.sv
// datapath: registers, scaling, window classing, green divider, stamps, result register
`default_nettype none

module cwm_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cwm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [cwm_pkg::DelayW-1:0]      cfg_data_i,
  input  wire logic [cwm_pkg::InDataW-1:0]     in_data_i,
  input  wire cwm_pkg::cwm_cmd_t               cmd_i,
  output cwm_pkg::cwm_status_t                 status_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [cwm_pkg::OutDataW-1:0]         m_axis_tdata
);

  // configuration registers
  logic signed [cwm_pkg::LimitW-1:0] temp_low_q, temp_high_q;
  logic [cwm_pkg::LimitW-1:0]        humid_low_q, humid_high_q;
  logic [cwm_pkg::DelayW-1:0]        delay_q;

  // working registers
  logic [cwm_pkg::ScaledW-1:0]  hx_q, tx_q;
  logic                         tneg_q;
  logic [cwm_pkg::TimeW-1:0]    now_q;
  logic [cwm_pkg::QuotW-1:0]    hq0_q, tq0_q;
  logic signed [7:0]            temp_q;
  logic [cwm_pkg::QuotW-1:0]    humid_q;
  logic [1:0]                   tclass_q, hclass_q;
  logic [cwm_pkg::LimitW-1:0]   span_q;
  logic [cwm_pkg::LimitW-1:0]   rem_q;
  logic [cwm_pkg::LevelW-1:0]   quo_q;
  logic [cwm_pkg::TimeW-1:0]    tstamp_q, hstamp_q;
  logic                         out_valid_q;
  logic [cwm_pkg::OutDataW-1:0] out_data_q;

  // input fields
  logic [cwm_pkg::SampleW-1:0] h_in, t_in;
  logic [cwm_pkg::TimeW-1:0]   now_in;
  assign h_in   = in_data_i[11:0];
  assign t_in   = in_data_i[23:12];
  assign now_in = in_data_i[55:24];

  // scaling numerators, constant products only
  logic [cwm_pkg::ScaledW-1:0] hx_d, tp, tx_d;
  logic                        tneg_d;
  always_comb begin
    if (h_in < cwm_pkg::AdcOffset) begin
      hx_d = '0;
    end else begin
      hx_d = 19'(h_in - cwm_pkg::AdcOffset) * 19'(cwm_pkg::HumidGain);
    end
    tp     = 19'(t_in) * 19'(cwm_pkg::TempGain);
    tneg_d = (tp < cwm_pkg::TempBias);
    tx_d   = tneg_d ? (cwm_pkg::TempBias - tp) : (tp - cwm_pkg::TempBias);
  end

  // reciprocal estimate of the division by full scale
  logic [38:0] hprod, tprod;
  assign hprod = {20'd0, hx_q} * {19'd0, cwm_pkg::RecipMul};
  assign tprod = {20'd0, tx_q} * {19'd0, cwm_pkg::RecipMul};

  // one correction step after the estimate
  function automatic logic [cwm_pkg::QuotW-1:0] fix_quot(
    input logic [cwm_pkg::ScaledW-1:0] x,
    input logic [cwm_pkg::QuotW-1:0]   q0
  );
    logic [cwm_pkg::ScaledW-1:0] back;
    logic [cwm_pkg::ScaledW-1:0] r;
    back = ({12'd0, q0} << 12) - ({12'd0, q0} << 5) + {12'd0, q0};
    r    = x - back;
    fix_quot = (r >= 19'(cwm_pkg::FullScale)) ? (q0 + 7'd1) : q0;
  endfunction

  logic [cwm_pkg::QuotW-1:0] hq_fix, tq_fix;
  logic [7:0]                tmag;
  assign hq_fix = fix_quot(hx_q, hq0_q);
  assign tq_fix = fix_quot(tx_q, tq0_q);
  assign tmag   = {1'b0, tq_fix};

  // window classing and green numerator
  logic signed [8:0] tdiff, tspan;
  logic              t_is_low, t_is_high, h_is_low, h_is_high;
  logic [1:0]        tclass_d, hclass_d;
  logic [19:0]       green_num;
  always_comb begin
    tdiff     = 9'(temp_q) - 9'(temp_low_q);
    tspan     = 9'(temp_high_q) - 9'(temp_low_q);
    t_is_low  = (temp_q < temp_low_q);
    t_is_high = (temp_q > temp_high_q);
    h_is_low  = ({1'b0, humid_q} < humid_low_q);
    h_is_high = ({1'b0, humid_q} > humid_high_q);
    if (t_is_low) begin
      tclass_d = cwm_pkg::ClassLow;
    end else if (t_is_high) begin
      tclass_d = cwm_pkg::ClassHigh;
    end else begin
      tclass_d = cwm_pkg::ClassNormal;
    end
    if (h_is_low) begin
      hclass_d = cwm_pkg::ClassLow;
    end else if (h_is_high) begin
      hclass_d = cwm_pkg::ClassHigh;
    end else begin
      hclass_d = cwm_pkg::ClassNormal;
    end
    green_num = 20'(tdiff[7:0]) * 20'(cwm_pkg::FullScale);
  end

  // restoring divide step, one quotient bit a cycle
  logic [8:0] rem_sh;
  logic       rem_ge;
  assign rem_sh = {rem_q, quo_q[cwm_pkg::LevelW-1]};
  assign rem_ge = (rem_sh >= {1'b0, span_q});

  // result assembly with updated stamps
  logic                       t_norm, h_norm, alarm;
  logic [cwm_pkg::TimeW-1:0]  tstamp_d, hstamp_d, t_elapsed, h_elapsed;
  logic [cwm_pkg::LevelW-1:0] red, green;
  always_comb begin
    t_norm    = (tclass_q == cwm_pkg::ClassNormal);
    h_norm    = (hclass_q == cwm_pkg::ClassNormal);
    tstamp_d  = t_norm ? now_q : tstamp_q;
    hstamp_d  = h_norm ? now_q : hstamp_q;
    t_elapsed = now_q - tstamp_d;
    h_elapsed = now_q - hstamp_d;
    alarm     = (t_elapsed > {16'd0, delay_q}) || (h_elapsed > {16'd0, delay_q});
    red       = (tclass_q == cwm_pkg::ClassHigh) ? cwm_pkg::FullScale : '0;
    green     = (t_norm && (span_q != '0)) ? quo_q : '0;
  end

  assign status_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid     = out_valid_q;
  assign m_axis_tdata      = out_data_q;

  // configuration, stamps and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q   <= cwm_pkg::TempLowReset;
      temp_high_q  <= cwm_pkg::TempHighReset;
      humid_low_q  <= cwm_pkg::HumidLowReset;
      humid_high_q <= cwm_pkg::HumidHighReset;
      delay_q      <= cwm_pkg::DelayReset;
      tstamp_q     <= '0;
      hstamp_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cwm_pkg::RegTempLow:   temp_low_q   <= cfg_data_i[7:0];
          cwm_pkg::RegTempHigh:  temp_high_q  <= cfg_data_i[7:0];
          cwm_pkg::RegHumidLow:  humid_low_q  <= cfg_data_i[7:0];
          cwm_pkg::RegHumidHigh: humid_high_q <= cfg_data_i[7:0];
          cwm_pkg::RegDelay:     delay_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load_out) begin
        tstamp_q    <= tstamp_d;
        hstamp_q    <= hstamp_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      hx_q   <= hx_d;
      tx_q   <= tx_d;
      tneg_q <= tneg_d;
      now_q  <= now_in;
    end
    if (cmd_i.scale_mul) begin
      hq0_q <= hprod[37:31];
      tq0_q <= tprod[37:31];
    end
    if (cmd_i.scale_fix) begin
      humid_q <= hq_fix;
      temp_q  <= tneg_q ? (8'd0 - tmag) : tmag;
    end
    if (cmd_i.classify) begin
      tclass_q <= tclass_d;
      hclass_q <= hclass_d;
      span_q   <= tspan[7:0];
      rem_q    <= green_num[19:12];
      quo_q    <= green_num[11:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 8'(rem_sh - {1'b0, span_q}) : rem_sh[7:0];
      quo_q <= {quo_q[cwm_pkg::LevelW-2:0], rem_ge};
    end
    if (cmd_i.load_out) begin
      out_data_q <= {4'd0, alarm, green, red, hclass_q, tclass_q, humid_q, temp_q};
    end
  end

endmodule

`default_nettype wire

>>> sim/climate_window_monitor_tb.sv
// self-checking testbench of the climate window monitor with its own reading predictor
`default_nettype none

module climate_window_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwm_pkg::*;

  localparam int Offset        = int'(AdcOffset);
  localparam int LevelMax      = int'(FullScale);
  localparam int LatencyCycles = 16;
  localparam int IdlePercent   = 17;
  localparam int WatchdogLimit = 2000;

  // one expected result item
  typedef struct {
    logic [7:0]  temp_value;
    logic [6:0]  humid_value;
    class_e      temp_class;
    class_e      humid_class;
    logic [11:0] red_level;
    logic [11:0] green_level;
    logic        alarm_on;
  } reading_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [DelayW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // humid_sample[11:0], temp_sample[23:12], now_ms[55:24]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // temp_value[7:0], humid_value[14:8], temp_class[16:15], humid_class[18:17],
  // red_level[30:19], green_level[42:31], alarm_on[43], zero[47:44]
  logic [OutDataW-1:0] m_axis_tdata;

  // predictor copy of the windows and the normal-time stamps
  int          win_temp_lo;
  int          win_temp_hi;
  int          win_humid_lo;
  int          win_humid_hi;
  logic [15:0] alarm_delay;
  logic [31:0] temp_ok_stamp;
  logic [31:0] humid_ok_stamp;

  reading_t    expected_readings[$];
  logic [31:0] sim_now_ms     = '0;
  bit          steady         = 1'b0;
  int          mismatch_count = 0;
  int          readings_sent  = 0;
  int          alarms_seen    = 0;
  int          window_count   = 0;
  int          quiet_cycles   = 0;

  climate_window_monitor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // scale, class and stamp one reading, as the block should
  function automatic reading_t climate_predict(logic [11:0] h_raw, logic [11:0] t_raw,
                                               logic [31:0] now);
    int          humid;
    int          temp;
    int          span;
    logic [31:0] temp_age;
    logic [31:0] humid_age;
    reading_t    r;
    humid = ((int'(h_raw) - Offset) * int'(HumidGain)) / LevelMax;
    temp  = ((int'(t_raw) - Offset) * int'(TempGain) - 10 * LevelMax) / LevelMax;
    r.red_level   = '0;
    r.green_level = '0;
    // temperature window and indicator levels
    if (temp < win_temp_lo) begin
      r.temp_class = ClassLow;
    end else if (temp > win_temp_hi) begin
      r.temp_class = ClassHigh;
      r.red_level  = 12'(LevelMax);
    end else begin
      r.temp_class = ClassNormal;
      span = win_temp_hi - win_temp_lo;
      if (span > 0) r.green_level = 12'(((temp - win_temp_lo) * LevelMax) / span);
      temp_ok_stamp = now;
    end
    // humidity window, negative readings clamp to zero
    if (humid < 0) humid = 0;
    if (humid < win_humid_lo) begin
      r.humid_class = ClassLow;
    end else if (humid > win_humid_hi) begin
      r.humid_class = ClassHigh;
    end else begin
      r.humid_class  = ClassNormal;
      humid_ok_stamp = now;
    end
    // elapsed times wrap with the millisecond counter
    temp_age  = now - temp_ok_stamp;
    humid_age = now - humid_ok_stamp;
    r.alarm_on    = (temp_age > {16'b0, alarm_delay}) || (humid_age > {16'b0, alarm_delay});
    r.temp_value  = 8'(temp);
    r.humid_value = 7'(humid);
    return r;
  endfunction

  // raw sample that scales to about the given degrees
  function automatic logic [11:0] raw_near_temp(int deg, bit jitter);
    int v;
    if (deg <= -10) return 12'($urandom_range(Offset + 30));
    v = Offset + ((deg + 10) * LevelMax + int'(TempGain) - 1) / int'(TempGain);
    if (jitter) v += int'($urandom_range(42));
    return (v > 4095) ? 12'hFFF : 12'(v);
  endfunction

  // raw sample that scales to about the given percent
  function automatic logic [11:0] raw_near_humid(int pct, bit jitter);
    int v;
    if (pct <= 0) return 12'($urandom_range(Offset + 20));
    v = Offset + (pct * LevelMax + int'(HumidGain) - 1) / int'(HumidGain);
    if (jitter) v += int'($urandom_range(40));
    return (v > 4095) ? 12'hFFF : 12'(v);
  endfunction

  // random value around a window, kept to the span the samples can reach
  function automatic int pick_near(int a, int b, int floor_v, int ceil_v);
    int lo;
    int hi;
    lo = ((a < b) ? a : b) - 3;
    hi = ((a < b) ? b : a) + 3;
    if (lo < floor_v) lo = floor_v;
    if (hi > ceil_v) hi = ceil_v;
    if (lo > hi) begin
      lo = floor_v;
      hi = ceil_v;
    end
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // send one reading and record its expected result at acceptance
  task automatic send_reading(input logic [11:0] h_raw, input logic [11:0] t_raw,
                              input logic [31:0] now);
    reading_t r;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, t_raw, h_raw};
    do @(posedge clk_i); while (!s_axis_tready);
    r = climate_predict(h_raw, t_raw, now);
    expected_readings.push_back(r);
    sim_now_ms = now;
    readings_sent++;
    if (r.alarm_on) alarms_seen++;
  endtask

  // stop sending and wait for every pending result
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTempLow:   win_temp_lo  = int'($signed(value[7:0]));
      RegTempHigh:  win_temp_hi  = int'($signed(value[7:0]));
      RegHumidLow:  win_humid_lo = int'(value[7:0]);
      RegHumidHigh: win_humid_hi = int'(value[7:0]);
      RegDelay:     alarm_delay  = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // all five registers, junk in the unused upper bits of the limits
  task automatic set_windows(input int t_lo, input int t_hi, input int h_lo, input int h_hi,
                             input int delay);
    write_window_reg(RegTempLow,   {8'($urandom), 8'(t_lo)});
    write_window_reg(RegTempHigh,  {8'($urandom), 8'(t_hi)});
    write_window_reg(RegHumidLow,  {8'($urandom), 8'(h_lo)});
    write_window_reg(RegHumidHigh, {8'($urandom), 8'(h_hi)});
    write_window_reg(RegDelay,     16'(delay));
    window_count++;
  endtask

  // mostly readings around the windows with a steadily advancing clock
  task automatic send_random_readings(input int count);
    int          pick;
    logic [11:0] h_raw;
    logic [11:0] t_raw;
    logic [31:0] now;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) begin
        t_raw = raw_near_temp(pick_near(win_temp_lo, win_temp_hi, -12, 88), 1'b1);
        h_raw = raw_near_humid(pick_near(win_humid_lo, win_humid_hi, -2, 103), 1'b1);
      end else begin
        t_raw = 12'($urandom);
        h_raw = 12'($urandom);
      end
      pick = $urandom_range(99);
      now  = sim_now_ms;
      if (pick < 85) now += $urandom_range(2 * int'(alarm_delay) + 4);
      else if (pick < 95) now += $urandom_range(3);
      else now = $urandom;
      send_reading(h_raw, t_raw, now);
    end
  endtask

  task automatic run_window_phase(input int t_lo, input int t_hi, input int h_lo,
                                  input int h_hi, input int delay, input int count);
    wait_for_results();
    set_windows(t_lo, t_hi, h_lo, h_hi, delay);
    send_random_readings(count);
  endtask

  // sample extremes, window edges, alarm timing and counter wrap on the reset windows
  task automatic test_directed_readings();
    send_reading(12'd0, 12'd0, 32'd0);
    send_reading(12'd15, 12'd15, 32'd5000);
    send_reading(12'(Offset), 12'(Offset), 32'd10000);
    send_reading(12'hFFF, 12'hFFF, 32'd10001);
    send_reading(raw_near_humid(50, 1'b0), raw_near_temp(30, 1'b0), 32'd20000);
    send_reading(raw_near_humid(30, 1'b0), raw_near_temp(20, 1'b0), 32'd25000);
    send_reading(raw_near_humid(70, 1'b0), raw_near_temp(37, 1'b0), 32'd26000);
    send_reading(raw_near_humid(71, 1'b0), raw_near_temp(38, 1'b0), 32'd36000);
    send_reading(raw_near_humid(29, 1'b0), raw_near_temp(19, 1'b0), 32'd36001);
    send_reading(raw_near_humid(50, 1'b0), raw_near_temp(30, 1'b0), 32'hFFFF_FFF0);
    send_reading(raw_near_humid(10, 1'b0), raw_near_temp(50, 1'b0), 32'h0000_0010);
    send_reading(raw_near_humid(10, 1'b0), raw_near_temp(50, 1'b0), 32'h0000_2720);
    send_reading(raw_near_humid(100, 1'b0), raw_near_temp(85, 1'b0), 32'hAAAA_AAAA);
    send_reading(12'hAAA, 12'h555, 32'h5555_5555);
    send_reading(12'h555, 12'hAAA, 32'hFFFF_FFFF);
  endtask

  // inverted, empty and widest windows, zero and longest delay
  task automatic test_window_extremes();
    run_window_phase(20, 37, 30, 70, 10000, 200);
    run_window_phase(40, 10, 80, 20, 5000, 150);
    run_window_phase(25, 25, 50, 50, 2000, 150);
    run_window_phase(-128, 127, 0, 255, 0, 150);
    run_window_phase(127, -128, 255, 0, 65535, 150);
    run_window_phase(18, 30, 40, 60, 0, 150);
  endtask

  // writes beyond the last register must leave the windows alone
  task automatic test_unused_indexes();
    wait_for_results();
    for (int i = int'(RegDelay) + 1; i < 2 ** CfgIdxW; i++) begin
      write_window_reg(CfgIdxW'(i), 16'($urandom));
    end
    send_random_readings(50);
  endtask

  task automatic test_random_windows();
    repeat (4) begin
      run_window_phase(int'($urandom_range(110)) - 20, int'($urandom_range(110)) - 20,
                       int'($urandom_range(110)), int'($urandom_range(110)),
                       int'($urandom_range(20000)), 100);
    end
  endtask

  // long stretch with neither side idling
  task automatic test_back_to_back();
    steady = 1'b1;
    send_random_readings(150);
    steady = 1'b0;
  endtask

  // sender holds off until the block has emptied, several times
  task automatic test_paused_sender();
    repeat (4) begin
      send_random_readings(25);
      wait_for_results();
    end
  endtask

  // receiver stalls at random unless in the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IdlePercent);
  end

  // compare each result item with the oldest expected reading
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        $error("result item with no reading pending: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("temp_value", int'($signed(want.temp_value)),
                    int'($signed(m_axis_tdata[7:0])));
        check_field("humid_value", int'(want.humid_value), int'(m_axis_tdata[14:8]));
        check_field("temp_class", int'(want.temp_class), int'(m_axis_tdata[16:15]));
        check_field("humid_class", int'(want.humid_class), int'(m_axis_tdata[18:17]));
        check_field("red_level", int'(want.red_level), int'(m_axis_tdata[30:19]));
        check_field("green_level", int'(want.green_level), int'(m_axis_tdata[42:31]));
        check_field("alarm_on", int'(want.alarm_on), int'(m_axis_tdata[43]));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no item moved for %0d cycles", WatchdogLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    win_temp_lo    = int'($signed(TempLowReset));
    win_temp_hi    = int'($signed(TempHighReset));
    win_humid_lo   = int'(HumidLowReset);
    win_humid_hi   = int'(HumidHighReset);
    alarm_delay    = DelayReset;
    temp_ok_stamp  = '0;
    humid_ok_stamp = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_readings();
    test_window_extremes();
    test_unused_indexes();
    test_random_windows();
    test_back_to_back();
    test_paused_sender();

    wait_for_results();
    repeat (LatencyCycles + 4) @(posedge clk_i);
    $display("%0d readings checked over %0d window settings plus the reset windows,",
             readings_sent, window_count);
    $display("%0d of them with the alarm raised, %0d mismatches", alarms_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
